@@ rtl/fsnf_pkg.sv @@
// ----------------------------------------------------------------------------
// fsnf_pkg
// Shared types, constants and helpers of the format string number formatter.
// ----------------------------------------------------------------------------
package fsnf_pkg;

  localparam int CHAR_W     = 8;
  localparam int ARG_W      = 32;
  localparam int MAX_DIGITS = 11;
  localparam int DIG_IDX_W  = $clog2(MAX_DIGITS);
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_LA      = 8'h61;
  localparam logic [CHAR_W-1:0] CH_C       = 8'h63;
  localparam logic [CHAR_W-1:0] CH_D       = 8'h64;
  localparam logic [CHAR_W-1:0] CH_O       = 8'h6f;
  localparam logic [CHAR_W-1:0] CH_P       = 8'h70;
  localparam logic [CHAR_W-1:0] CH_U       = 8'h75;
  localparam logic [CHAR_W-1:0] CH_X       = 8'h78;

  localparam logic [ARG_W-1:0] RECIP10 = 32'hcccccccd;
  localparam int RECIP10_SHIFT = 35;

  localparam logic [2:0] CMD_CHAR = 3'd0;
  localparam logic [2:0] CMD_HEX  = 3'd1;
  localparam logic [2:0] CMD_OCT  = 3'd2;
  localparam logic [2:0] CMD_DEC  = 3'd3;
  localparam logic [2:0] CMD_PTR  = 3'd4;

  typedef struct packed {
    logic [2:0]       kind;
    logic             neg;
    logic [ARG_W-1:0] data;
  } cmd_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'b0000, d};
    end else begin
      c = CH_LA + {4'b0000, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

@@ rtl/format_string_number_formatter.sv @@
// ----------------------------------------------------------------------------
// format_string_number_formatter
// Printf-style integer formatter: format bytes in, ASCII text bytes out.
// ----------------------------------------------------------------------------
// Each input transaction carries one format byte and a 32-bit argument; the
// front part takes a transaction whenever the command queue has room. The
// back part starts each queued command, then sends one output byte per
// cycle when the output is not stalled. A plain byte, 'c' or '%%' goes
// straight out; 'x', 'o' and 'p' first build their digits one per step; 'u'
// and 'd' take a multiply step and a digit step per digit for the
// multiply-by-reciprocal divide by ten.
// ----------------------------------------------------------------------------
module format_string_number_formatter import fsnf_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] fmt_char, [39:8] arg_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_char
  output logic        out_tlast
);

  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  fsnf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .fmt_char  (in_tdata[7:0]),
    .arg_value (in_tdata[39:8]),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  fsnf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  fsnf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

@@ rtl/fsnf_front.sv @@
// ----------------------------------------------------------------------------
// fsnf_front
// Accepts format bytes, tracks the pending percent and queues commands.
// ----------------------------------------------------------------------------
module fsnf_front import fsnf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAR_W-1:0] fmt_char,
  input  logic [ARG_W-1:0]  arg_value,
  input  logic              q_full,
  output logic              q_push,
  output cmd_t              q_cmd
);

  logic pending_r;
  logic pending_nxt;
  logic accept;
  logic emit;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && emit;

  always_comb begin
    emit        = 1'b1;
    pending_nxt = 1'b0;
    q_cmd.kind  = CMD_CHAR;
    q_cmd.neg   = 1'b0;
    q_cmd.data  = {{(ARG_W-CHAR_W){1'b0}}, fmt_char};
    if (!pending_r) begin
      if (fmt_char == CH_PERCENT) begin
        emit        = 1'b0;
        pending_nxt = 1'b1;
      end
    end else begin
      case (fmt_char)
        CH_NUL: begin
          q_cmd.kind = CMD_CHAR;
        end
        CH_X: begin
          q_cmd.kind = CMD_HEX;
          q_cmd.data = arg_value;
        end
        CH_O: begin
          q_cmd.kind = CMD_OCT;
          q_cmd.data = arg_value;
        end
        CH_U: begin
          q_cmd.kind = CMD_DEC;
          q_cmd.data = arg_value;
        end
        CH_P: begin
          q_cmd.kind = CMD_PTR;
          q_cmd.data = arg_value;
        end
        CH_D: begin
          q_cmd.kind = CMD_DEC;
          q_cmd.neg  = arg_value[ARG_W-1];
          q_cmd.data = arg_value[ARG_W-1] ? (~arg_value + 1'b1) : arg_value;
        end
        CH_C: begin
          q_cmd.data = {{(ARG_W-CHAR_W){1'b0}}, arg_value[CHAR_W-1:0]};
        end
        CH_PERCENT: begin
          q_cmd.data = {{(ARG_W-CHAR_W){1'b0}}, CH_PERCENT};
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
    end else if (accept) begin
      pending_r <= pending_nxt;
    end
  end

endmodule

@@ rtl/fsnf_queue.sv @@
// ----------------------------------------------------------------------------
// fsnf_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module fsnf_queue import fsnf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic full,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == DEPTH_CNT);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_CNT)
    else $error("queue count exceeds depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");
`endif

endmodule

@@ rtl/fsnf_back.sv @@
// ----------------------------------------------------------------------------
// fsnf_back
// Runs queued commands: builds the digits of a number one per step, then streams the text.
// ----------------------------------------------------------------------------
module fsnf_back import fsnf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  cmd_t              q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_last
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHAR = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIG  = 3'd3;
  localparam logic [2:0] S_SIGN = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  localparam int QUO_W = 2 * ARG_W - RECIP10_SHIFT;

  logic [2:0]             state_r, state_nxt;
  logic [2:0]             kind_r;
  logic                   neg_r;
  logic [ARG_W-1:0]       val_r, val_nxt;
  logic [2*ARG_W-1:0]     prod_r;
  logic [DIG_IDX_W-1:0]   cnt_r, cnt_nxt;
  logic [DIG_IDX_W-1:0]   idx_r, idx_nxt;
  logic [3:0]             dig_r [MAX_DIGITS];
  logic                   load_cmd;
  logic                   dig_we;

  logic                   out_valid_r;
  logic [CHAR_W-1:0]      out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   out_free;
  logic                   out_ld;

  logic [QUO_W-1:0]       quo;
  logic [3:0]             q10_lo;
  logic [3:0]             digit;
  logic [ARG_W-1:0]       next_val;
  logic                   conv_done;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  assign quo    = prod_r[2*ARG_W-1:RECIP10_SHIFT];
  assign q10_lo = {quo[0], 3'b000} + {quo[2:0], 1'b0};

  always_comb begin
    case (kind_r)
      CMD_OCT: begin
        digit    = {1'b0, val_r[2:0]};
        next_val = val_r >> 3;
      end
      CMD_DEC: begin
        digit    = val_r[3:0] - q10_lo;
        next_val = {{(ARG_W-QUO_W){1'b0}}, quo};
      end
      default: begin
        digit    = val_r[3:0];
        next_val = val_r >> 4;
      end
    endcase
    conv_done = (next_val == '0) &&
                ((kind_r != CMD_PTR) || (cnt_r == DIG_IDX_W'(7)));
  end

  always_comb begin
    state_nxt    = state_r;
    val_nxt      = val_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    load_cmd     = 1'b0;
    dig_we       = 1'b0;
    out_ld       = 1'b0;
    out_char_nxt = out_char_r;
    out_last_nxt = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          load_cmd = 1'b1;
          val_nxt  = q_cmd.data;
          cnt_nxt  = '0;
          case (q_cmd.kind)
            CMD_CHAR: state_nxt = S_CHAR;
            CMD_DEC:  state_nxt = S_MUL;
            default:  state_nxt = S_DIG;
          endcase
        end
      end
      S_CHAR: begin
        if (out_free) begin
          out_ld       = 1'b1;
          out_char_nxt = val_r[CHAR_W-1:0];
          out_last_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_MUL: begin
        state_nxt = S_DIG;
      end
      S_DIG: begin
        dig_we  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        val_nxt = next_val;
        if (conv_done) begin
          idx_nxt   = cnt_r;
          state_nxt = neg_r ? S_SIGN : S_EMIT;
        end else begin
          state_nxt = (kind_r == CMD_DEC) ? S_MUL : S_DIG;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          out_ld       = 1'b1;
          out_char_nxt = CH_MINUS;
          out_last_nxt = 1'b0;
          state_nxt    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_ld       = 1'b1;
          out_char_nxt = digit_char(dig_r[idx_r]);
          out_last_nxt = (idx_r == '0);
          idx_nxt      = idx_r - 1'b1;
          if (idx_r == '0) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign q_pop = load_cmd;

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    cnt_r  <= cnt_nxt;
    idx_r  <= idx_nxt;
    prod_r <= {{ARG_W{1'b0}}, val_r} * {{ARG_W{1'b0}}, RECIP10};
    if (load_cmd) begin
      kind_r <= q_cmd.kind;
      neg_r  <= q_cmd.neg;
    end
    if (dig_we) begin
      dig_r[cnt_r] <= digit;
    end
    if (out_ld) begin
      out_char_r <= out_char_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_emit_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT || state_r == S_SIGN) |-> (idx_r < cnt_r))
    else $error("emit index outside digit buffer");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ld && out_last_nxt) |=> (state_r == S_IDLE))
    else $error("run closed while command still active");
`endif

endmodule

@@ sim/fsnf_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fsnf_checker
// Watches both streams of the formatter, predicts its text and compares.
// ----------------------------------------------------------------------------
// Every accepted input transaction is run through a local formatter that keeps
// its own pending-percent flag and queues the text bytes the block must emit,
// each with its end-of-run mark. Every accepted output transaction is checked
// against the oldest queued byte. Output with nothing queued and any wrong
// byte or mark count as failures.
// ----------------------------------------------------------------------------
module fsnf_checker import fsnf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] fmt_char, [39:8] arg_value
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // [7:0] out_char
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending_count
);

  localparam int RUN_MAX = 11;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_byte_t;

  text_byte_t        text_q[$];
  logic              pct_armed;
  logic [CHAR_W-1:0] run_buf [0:39];
  int                run_len;

  task automatic add_digits(input logic [ARG_W-1:0] value, input logic [ARG_W-1:0] base,
                            input int min_len);
    logic [CHAR_W-1:0] rev [0:31];
    logic [ARG_W-1:0]  v;
    logic [ARG_W-1:0]  d;
    logic              more;
    int                n;
    int                i;
    v = value;
    n = 0;
    more = 1'b1;
    while (more) begin
      d = v % base;
      rev[n] = (d < 10) ? CH_ZERO + d[7:0] : CH_LA + d[7:0] - 8'd10;
      n++;
      v = v / base;
      more = (v != 0) && (n < 32);
    end
    while (n < min_len) begin
      rev[n] = CH_ZERO;
      n++;
    end
    for (i = n - 1; i >= 0; i--) begin
      run_buf[run_len] = rev[i];
      run_len++;
    end
  endtask

  task automatic format_byte(input logic [CHAR_W-1:0] c, input logic [ARG_W-1:0] arg);
    run_len = 0;
    if (!pct_armed) begin
      if (c == CH_PERCENT) begin
        pct_armed = 1'b1;
      end else begin
        run_buf[0] = c;
        run_len = 1;
      end
    end else begin
      pct_armed = 1'b0;
      case (c)
        CH_NUL: begin
          run_buf[0] = CH_NUL;
          run_len = 1;
        end
        CH_X: add_digits(arg, 16, 1);
        CH_O: add_digits(arg, 8, 1);
        CH_U: add_digits(arg, 10, 1);
        CH_P: add_digits(arg, 16, 8);
        CH_D: begin
          if (arg[ARG_W-1]) begin
            run_buf[0] = CH_MINUS;
            run_len = 1;
            add_digits(32'd0 - arg, 10, 1);
          end else begin
            add_digits(arg, 10, 1);
          end
        end
        CH_C: begin
          run_buf[0] = arg[7:0];
          run_len = 1;
        end
        CH_PERCENT: begin
          run_buf[0] = CH_PERCENT;
          run_len = 1;
        end
        default: ;
      endcase
    end
    if (run_len > RUN_MAX) run_len = RUN_MAX;
  endtask

  always @(posedge clk) begin
    text_byte_t want;
    int         k;
    if (!rst_n) begin
      pct_armed = 1'b0;
      text_q.delete();
      pending_count <= 0;
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        format_byte(in_tdata[7:0], in_tdata[39:8]);
        for (k = 0; k < run_len; k++) begin
          want.ch = run_buf[k];
          want.last = (k == run_len - 1);
          text_q.push_back(want);
        end
      end
      if (out_tvalid && out_tready) begin
        if (text_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected output transaction: char %h last %b", out_tdata, out_tlast);
          fail_count <= fail_count + 1;
        end else begin
          want = text_q.pop_front();
          if (want.ch !== out_tdata || want.last !== out_tlast) begin
            if (fail_count < 10)
              $display("mismatch: expected char %h last %b, got char %h last %b",
                       want.ch, want.last, out_tdata, out_tlast);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_count <= text_q.size();
    end
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the format string number formatter.
// ----------------------------------------------------------------------------
// Sends a short directed format string covering byte extremes, every
// conversion, zero, the most negative decimal, a percent before the
// terminator and an unsupported selector, then random format strings made
// mostly of percent-conversion pairs with random arguments. Both streams idle
// at random; the receiver also holds off for a long stretch so the block
// backs up into its input. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import fsnf_pkg::*;

  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_S_UNSUP = 8'h73;
  localparam int RANDOM_ITEMS = 196;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 64;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  logic        quiet = 1'b0;
  logic        hold_go = 1'b0;
  logic        hold_taken = 1'b0;
  int          hold_left = 0;
  int          fail_count;
  int          pending_count;

  always #5 clk = ~clk;

  format_string_number_formatter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  fsnf_checker text_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 26);
    end
  end

  function automatic logic [ARG_W-1:0] rand_arg();
    logic [ARG_W-1:0] a;
    case ($urandom_range(3))
      0: a = $urandom;
      1: a = $urandom_range(15);
      2: a = $urandom >> $urandom_range(31);
      default: begin
        case ($urandom_range(3))
          0: a = 32'h0000_0000;
          1: a = 32'hffff_ffff;
          2: a = 32'h8000_0000;
          default: a = 32'h7fff_ffff;
        endcase
      end
    endcase
    return a;
  endfunction

  function automatic logic [CHAR_W-1:0] rand_conv();
    logic [CHAR_W-1:0] c;
    case ($urandom_range(9))
      0: c = CH_X;
      1: c = CH_O;
      2: c = CH_U;
      3: c = CH_D;
      4: c = CH_P;
      5: c = CH_C;
      6: c = CH_PERCENT;
      7: c = CH_NUL;
      8: c = CH_S_UNSUP;
      default: c = CHAR_W'($urandom_range(255));
    endcase
    return c;
  endfunction

  task automatic send_item(input logic [CHAR_W-1:0] c, input logic [ARG_W-1:0] a);
    int gap;
    gap = 0;
    if (!quiet)
      while ($urandom_range(99) < 26) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {a, c};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_text_done();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  initial begin
    int sent;
    int pick;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(CH_UPPER_A, 32'h0);
    send_item(8'hff, 32'hffff_ffff);
    send_item(CH_PERCENT, 32'h0); send_item(CH_X, 32'h0000_0000);
    send_item(CH_PERCENT, 32'h0); send_item(CH_X, 32'hffff_ffff);
    send_item(CH_PERCENT, 32'h0); send_item(CH_O, 32'hffff_ffff);
    send_item(CH_PERCENT, 32'h0); send_item(CH_U, 32'hffff_ffff);
    send_item(CH_PERCENT, 32'h0); send_item(CH_D, 32'h8000_0000);
    send_item(CH_PERCENT, 32'h0); send_item(CH_D, 32'h7fff_ffff);
    send_item(CH_PERCENT, 32'h0); send_item(CH_P, 32'h0000_0000);
    send_item(CH_PERCENT, 32'h0); send_item(CH_C, 32'hffff_ff00);
    send_item(CH_PERCENT, 32'h0); send_item(CH_PERCENT, 32'h1234_5678);
    send_item(CH_PERCENT, 32'h0); send_item(CH_NUL, 32'h0);
    send_item(CH_PERCENT, 32'h0); send_item(CH_S_UNSUP, 32'hdead_beef);
    send_item(CH_NUL, 32'h0);
    wait_text_done();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= 40 && !hold_go) hold_go <= 1'b1;
      quiet <= (sent >= 120 && sent < 170);
      pick = $urandom_range(99);
      if (pick < 60) begin
        send_item(CH_PERCENT, rand_arg());
        send_item(rand_conv(), rand_arg());
        sent += 2;
      end else if (pick < 88) begin
        send_item(CHAR_W'($urandom_range(8'h7e, 8'h20)), rand_arg());
        sent++;
      end else begin
        send_item(CHAR_W'($urandom_range(255)), rand_arg());
        sent++;
      end
      if (sent >= 180 && sent < 182) begin
        wait_text_done();
      end
    end

    wait_text_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("format_string_number_formatter test passed");
    end else begin
      $display("format_string_number_formatter test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("format_string_number_formatter test failed");
    $finish;
  end

endmodule
